// ===== design/pfcc_pkg.sv =====
// Package for the prefix-free code checker: defaults, field widths,
// input kind codes, controller states and the control/status structs.
// No dependencies.
`timescale 1ns / 1ps

package pfcc_pkg;

	localparam int MAX_CODE_LEN_DEF = 16;
	localparam int POOL_NODES_DEF   = 256;

	localparam int BITS_W = 16;   // code_bits width
	localparam int LEN_W  = 5;    // code_len width
	localparam int SET_W  = 16;   // set_index width

	localparam logic KIND_WORD = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_REPORT
	} ctrl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_word;   // latch a code word, start at the root
		logic walk;        // take one trie step
		logic report;      // load the verdict, clear the trie
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic still_ok;    // set still prefix-free, words are inserted
		logic walk_end;    // this step finishes the word
		logic out_free;    // result register can take a new verdict
	} dp_sts_t;

endpackage

// ===== design/pfcc_ctrl.sv =====
// Controller for the prefix-free code checker: sequences word walks and
// end-of-set reports. Depends on pfcc_pkg.
`timescale 1ns / 1ps

module pfcc_ctrl import pfcc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    word_valid,
	output logic    word_stall,
	input  logic    kind,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		word_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				word_stall = 1'b0;
				if (word_valid) begin
					if (kind == KIND_END) begin
						state_d = ST_REPORT;
					end else if (sts.still_ok) begin
						cmd.load_word = 1'b1;
						state_d       = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (sts.walk_end) begin
					state_d = ST_IDLE;
				end
			end
			ST_REPORT: begin
				if (sts.out_free) begin
					cmd.report = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/pfcc_dpath.sv =====
// Datapath for the prefix-free code checker: trie node pool, walk registers,
// set status and the result register. Depends on pfcc_pkg.
`timescale 1ns / 1ps

module pfcc_dpath import pfcc_pkg::*; #(
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
	parameter int POOL_NODES   = POOL_NODES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_sts_t           sts,
	input  logic [BITS_W-1:0] code_bits,
	input  logic [LEN_W-1:0]  code_len,
	output logic              result_valid,
	input  logic              result_stall,
	output logic              decodable,
	output logic [SET_W-1:0]  set_index,
	output logic              pool_overflow
);

	localparam int NW    = $clog2(POOL_NODES);
	localparam int ENT_W = 2 * NW + 1;
	localparam int CAP   = (MAX_CODE_LEN > (2**LEN_W - 1)) ? (2**LEN_W - 1) : MAX_CODE_LEN;

	// entry layout: {leaf, one_child, zero_child}
	logic [ENT_W-1:0] mem [POOL_NODES];
	logic [ENT_W-1:0] rd_data_q;
	logic             rd_en;
	logic [NW-1:0]    rd_addr;
	logic             wr_en;
	logic [NW-1:0]    wr_addr;
	logic [ENT_W-1:0] wr_data;

	logic [BITS_W-1:0] bits_q;
	logic [LEN_W-1:0]  remain_q;
	logic [NW-1:0]     node_q;
	logic              fresh_q;     // current node not yet in memory, reads as empty
	logic [NW:0]       nodes_used_q;
	logic              still_ok_q;
	logic              ovf_q;
	logic              root_clear_q;
	logic [SET_W-1:0]  set_cnt_q;
	logic              out_valid_q;
	logic              out_dec_q;
	logic [SET_W-1:0]  out_set_q;
	logic              out_ovf_q;

	logic [ENT_W-1:0]  ent;
	logic              ent_leaf;
	logic [NW-1:0]     ent_one;
	logic [NW-1:0]     ent_zero;
	logic [LEN_W-1:0]  bit_idx;
	logic              cur_bit;
	logic [NW-1:0]     child;
	logic              pool_full;
	logic [NW-1:0]     new_node;
	logic              at_end;
	logic              step_fail;
	logic              step_alloc;
	logic              step_move;

	assign ent      = fresh_q ? '0 : rd_data_q;
	assign ent_leaf = ent[ENT_W-1];
	assign ent_one  = ent[2*NW-1:NW];
	assign ent_zero = ent[NW-1:0];

	assign bit_idx  = remain_q - LEN_W'(1);
	assign cur_bit  = (bit_idx < LEN_W'(BITS_W)) ? bits_q[bit_idx[$clog2(BITS_W)-1:0]] : 1'b0;
	assign child    = cur_bit ? ent_one : ent_zero;

	assign pool_full = (nodes_used_q == (NW+1)'(POOL_NODES));
	assign new_node  = nodes_used_q[NW-1:0];
	assign at_end    = (remain_q == '0);

	// word breaks the code: passes a leaf, or ends on a leaf or an inner node
	assign step_fail  = cmd.walk && (ent_leaf ||
		(at_end && ((ent_one != '0) || (ent_zero != '0))));
	assign step_move  = cmd.walk && !at_end && !ent_leaf && (child != '0);
	assign step_alloc = cmd.walk && !at_end && !ent_leaf && (child == '0) && !pool_full;

	assign sts.still_ok = still_ok_q;
	assign sts.walk_end = at_end || ent_leaf || ((child == '0) && pool_full);
	assign sts.out_free = !out_valid_q || !result_stall;

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = node_q;
		wr_data = ent;
		if (cmd.load_word) begin
			rd_en = !root_clear_q;
		end
		if (step_move) begin
			rd_en   = 1'b1;
			rd_addr = child;
		end
		if (cmd.walk && !step_fail) begin
			if (at_end) begin
				wr_en   = 1'b1;
				wr_data = {1'b1, ent_one, ent_zero};
			end else if (step_alloc) begin
				wr_en   = 1'b1;
				wr_data = cur_bit ? {1'b0, new_node, ent_zero} : {1'b0, ent_one, new_node};
			end else if (!step_move) begin
				// pool full: the node still has to land in memory
				wr_en = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_word) begin
			bits_q   <= code_bits;
			remain_q <= (code_len > LEN_W'(CAP)) ? LEN_W'(CAP) : code_len;
		end else if (step_move || step_alloc) begin
			remain_q <= remain_q - LEN_W'(1);
		end
		if (cmd.report) begin
			out_dec_q <= still_ok_q;
			out_set_q <= set_cnt_q;
			out_ovf_q <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q       <= '0;
			fresh_q      <= 1'b1;
			nodes_used_q <= (NW+1)'(1);
			still_ok_q   <= 1'b1;
			ovf_q        <= 1'b0;
			root_clear_q <= 1'b1;
			set_cnt_q    <= SET_W'(1);
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load_word) begin
				node_q  <= '0;
				fresh_q <= root_clear_q;
			end else if (step_move) begin
				node_q  <= child;
				fresh_q <= 1'b0;
			end else if (step_alloc) begin
				node_q       <= new_node;
				fresh_q      <= 1'b1;
				nodes_used_q <= nodes_used_q + (NW+1)'(1);
			end
			if (wr_en && (wr_addr == '0)) begin
				root_clear_q <= 1'b0;
			end
			if (step_fail) begin
				still_ok_q <= 1'b0;
			end
			if (cmd.walk && !at_end && !ent_leaf && (child == '0) && pool_full) begin
				ovf_q <= 1'b1;
			end
			if (cmd.report) begin
				set_cnt_q    <= (set_cnt_q == '1) ? SET_W'(1) : set_cnt_q + SET_W'(1);
				still_ok_q   <= 1'b1;
				ovf_q        <= 1'b0;
				nodes_used_q <= (NW+1)'(1);
				root_clear_q <= 1'b1;
				out_valid_q  <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid  = out_valid_q;
	assign decodable     = out_dec_q;
	assign set_index     = out_set_q;
	assign pool_overflow = out_ovf_q;

endmodule

// ===== design/prefix_free_code_checker.sv =====
// Top level of the prefix-free code checker: binary trie in a node pool.
// Instantiates pfcc_ctrl and pfcc_dpath; depends on pfcc_pkg.
`timescale 1ns / 1ps

//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------
//  word     | word_valid / word_stall    | kind, code_bits, code_len
//  result   | result_valid / result_stall| decodable, set_index, pool_overflow
//
// A code word of n effective bits (code_len capped at MAX_CODE_LEN) runs
// through the accept step, one trie step per bit and the final leaf mark,
// each step one read and at most one write of the single-port node pool.
// A word arriving after the set has failed is accepted and dropped; an end
// of set leads to the result load. word_stall is high while a walk or report runs.
// A waiting result does not block words; only the next end of set waits for it.
// Reset is asynchronous; the pool needs no clearing pass (the root reads as
// empty until written, other nodes are written by the walk that allocates them).

module prefix_free_code_checker import pfcc_pkg::*; #(
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
	parameter int POOL_NODES   = POOL_NODES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// word channel: one transaction per code word or end of set
	input  logic              word_valid,
	output logic              word_stall,
	input  logic              kind,
	input  logic [BITS_W-1:0] code_bits,
	input  logic [LEN_W-1:0]  code_len,
	// result channel: one transaction per finished set
	output logic              result_valid,
	input  logic              result_stall,
	output logic              decodable,
	output logic [SET_W-1:0]  set_index,
	output logic              pool_overflow
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencing: idle / walk / report
	pfcc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.kind       (kind),
		.sts        (sts),
		.cmd        (cmd)
	);

	// node pool, walk state and result register
	pfcc_dpath #(
		.MAX_CODE_LEN (MAX_CODE_LEN),
		.POOL_NODES   (POOL_NODES)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.code_bits     (code_bits),
		.code_len      (code_len),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.decodable     (decodable),
		.set_index     (set_index),
		.pool_overflow (pool_overflow)
	);

endmodule
